/* rtl/nca_pkg.sv */
// Shared types, constants and the control program of the nearest-centre assign unit.
package nca_pkg;

  localparam int NUM_CENTERS_DEF = 1024;
  localparam int DIMENSIONS_DEF  = 128;

  localparam int MODE_W   = 1;
  localparam int IN_CIDX_W = 10;
  localparam int COMP_W   = 7;
  localparam int CVAL_W   = 16;
  localparam int DVAL_W   = 8;
  localparam int ACT_W    = 11;
  localparam int BEST_W   = 10;
  localparam int DIST_W   = 39;
  localparam int SQ_W     = 32;

  localparam logic [ACT_W-1:0] ACTIVE_RESET = 11'd1000;
  localparam logic [MODE_W-1:0] MODE_LOAD  = 1'b0;
  localparam logic [MODE_W-1:0] MODE_QUERY = 1'b1;

  localparam int STEP_W = 3;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t S_IDLE  = 3'd0;
  localparam step_t S_INIT  = 3'd1;
  localparam step_t S_ISSUE = 3'd2;
  localparam step_t S_DRN0  = 3'd3;
  localparam step_t S_DRN1  = 3'd4;
  localparam step_t S_CMP   = 3'd5;
  localparam step_t S_EMIT  = 3'd6;
  localparam step_t S_BACK  = 3'd7;

  typedef enum logic [2:0] {
    C_NEXT       = 3'd0,
    C_ALWAYS     = 3'd1,
    C_WAIT_START = 3'd2,
    C_D_MORE     = 3'd3,
    C_C_MORE     = 3'd4,
    C_OUT_BUSY   = 3'd5
  } cond_code_t;

  typedef struct packed {
    logic accept;
    logic init;
    logic issue;
    logic cmp;
    logic emit;
  } ctrl_t;

  typedef struct packed {
    logic start;
    logic d_more;
    logic c_more;
    logic out_busy;
  } seq_cond_t;

  typedef struct packed {
    ctrl_t      ctrl;
    cond_code_t cond;
    step_t      target;
  } ucode_t;

  function automatic ucode_t ucode_rom(input step_t s);
    ucode_t w;
    w = '{ctrl: '0, cond: C_NEXT, target: S_IDLE};
    case (s)
      S_IDLE: begin
        w.ctrl.accept = 1'b1;
        w.cond        = C_WAIT_START;
        w.target      = S_IDLE;
      end
      S_INIT: begin
        w.ctrl.init = 1'b1;
      end
      S_ISSUE: begin
        w.ctrl.issue = 1'b1;
        w.cond       = C_D_MORE;
        w.target     = S_ISSUE;
      end
      S_DRN0: begin
      end
      S_DRN1: begin
      end
      S_CMP: begin
        w.ctrl.cmp = 1'b1;
        w.cond     = C_C_MORE;
        w.target   = S_ISSUE;
      end
      S_EMIT: begin
        w.ctrl.emit = 1'b1;
        w.cond      = C_OUT_BUSY;
        w.target    = S_EMIT;
      end
      S_BACK: begin
        w.cond   = C_ALWAYS;
        w.target = S_IDLE;
      end
      default: begin
        w.cond   = C_ALWAYS;
        w.target = S_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

/* rtl/nca_seq.sv */
// Microcode sequencer: step counter, control ROM and conditional jumps.
module nca_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  nca_pkg::seq_cond_t cond,
  output nca_pkg::ctrl_t     ctrl
);
  import nca_pkg::*;

  step_t  step_r, step_nxt;
  ucode_t uw;
  logic   jump;

  assign uw   = ucode_rom(step_r);
  assign ctrl = uw.ctrl;

  always_comb begin
    case (uw.cond)
      C_NEXT:       jump = 1'b0;
      C_ALWAYS:     jump = 1'b1;
      C_WAIT_START: jump = !cond.start;
      C_D_MORE:     jump = cond.d_more;
      C_C_MORE:     jump = cond.c_more;
      C_OUT_BUSY:   jump = cond.out_busy;
      default:      jump = 1'b1;
    endcase
    step_nxt = jump ? uw.target : step_t'(step_r + 1'b1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= S_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

/* rtl/nearest_centroid_assign_unit.sv */
// Top level: centre store, query buffer, distance datapath and result register.
//
// Nearest-centre assign unit. Input requests on in_* (valid/stall) are either
// loads (in_mode 0: one centre component into the store) or query components
// (in_mode 1: one descriptor component). Loads and non-final query components
// cause no stall. The query component with index DIMENSIONS-1 starts a
// scan over centres 0..active_centers-1 (0 counts as 1, large values clip to
// NUM_CENTERS); in_stall stays high for the whole scan.
// The scan does one multiply-accumulate per cycle while components issue,
// through a single centre-store read port; each centre then drains through
// S_DRN0 and S_DRN1 and is compared in S_CMP. After the last centre the result
// (best_center, best_distance, first index on a tie) is held in an output
// register until taken on out_*; further requests are accepted meanwhile, and
// a following scan waits at its end while out_stall keeps the previous result
// pending.
// cfg_wr_en/cfg_wr_data set active_centers; write only while idle.
// Synchronous reset clears control and sets active_centers to 1000. Store and
// query buffer are not cleared and must be written before they are scanned.
module nearest_centroid_assign_unit #(
  parameter int NUM_CENTERS = nca_pkg::NUM_CENTERS_DEF,
  parameter int DIMENSIONS  = nca_pkg::DIMENSIONS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [nca_pkg::ACT_W-1:0]    cfg_wr_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [nca_pkg::MODE_W-1:0]   in_mode,
  input  logic [nca_pkg::IN_CIDX_W-1:0] in_center_index,
  input  logic [nca_pkg::COMP_W-1:0]   in_component_index,
  input  logic [nca_pkg::CVAL_W-1:0]   in_center_value,
  input  logic [nca_pkg::DVAL_W-1:0]   in_descriptor_value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [nca_pkg::BEST_W-1:0]   out_best_center,
  output logic [nca_pkg::DIST_W-1:0]   out_best_distance
);
  import nca_pkg::*;

  localparam int CIDX_W    = (NUM_CENTERS > 1) ? $clog2(NUM_CENTERS) : 1;
  localparam int DIDX_W    = (DIMENSIONS > 1) ? $clog2(DIMENSIONS) : 1;
  localparam int MEM_DEPTH = NUM_CENTERS * DIMENSIONS;
  localparam int MEM_AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int ACC_W     = SQ_W + $clog2(DIMENSIONS);
  localparam int SUM_W     = (ACC_W > DIST_W) ? ACC_W : DIST_W;
  localparam int CNT_NW    = $clog2(NUM_CENTERS + 1);
  localparam int EW        = (CNT_NW > ACT_W) ? CNT_NW : ACT_W;

  ctrl_t     ctrl;
  seq_cond_t cond;

  logic [CVAL_W-1:0] center_mem [MEM_DEPTH];
  logic [DVAL_W-1:0] qbuf_mem [DIMENSIONS];

  logic [ACT_W-1:0]  act_r;
  logic [CIDX_W-1:0] c_r, c_nxt, last_r, best_c_r;
  logic [DIDX_W-1:0] d_r, d_nxt;
  logic [MEM_AW-1:0] addr_r, addr_nxt;
  logic [CVAL_W-1:0] cv_r;
  logic [DVAL_W-1:0] qv_r;
  logic              v1_r, v2_r;
  logic [SQ_W-1:0]   sq_r;
  logic [ACC_W-1:0]  acc_r, best_d_r;
  logic              out_valid_r;
  logic [BEST_W-1:0] out_c_r;
  logic [DIST_W-1:0] out_d_r;

  logic              accepted, load_we, query_we;
  logic [MEM_AW-1:0] wr_addr;
  logic [EW-1:0]     act_ext, cnt;
  logic signed [CVAL_W:0] diff;
  logic [CVAL_W-1:0] mag;
  logic [SQ_W-1:0]   mag_w;
  logic              out_busy, out_load, take_best;
  logic [SUM_W-1:0]  best_ext;

  nca_seq u_seq (
    .clk  (clk),
    .rst_n(rst_n),
    .cond (cond),
    .ctrl (ctrl)
  );

  assign in_stall = !ctrl.accept;
  assign accepted = in_valid && ctrl.accept;
  assign load_we  = accepted && (in_mode == MODE_LOAD) &&
                    (32'(in_center_index) < NUM_CENTERS) &&
                    (32'(in_component_index) < DIMENSIONS);
  assign query_we = accepted && (in_mode == MODE_QUERY) &&
                    (32'(in_component_index) < DIMENSIONS);
  assign wr_addr  = MEM_AW'(MEM_AW'(CIDX_W'(in_center_index)) * MEM_AW'(DIMENSIONS)) +
                    MEM_AW'(DIDX_W'(in_component_index));

  assign out_busy = out_valid_r && out_stall;
  assign out_load = ctrl.emit && !out_busy;

  assign cond.start    = accepted && (in_mode == MODE_QUERY) &&
                         (32'(in_component_index) == DIMENSIONS - 1);
  assign cond.d_more   = (32'(d_r) != DIMENSIONS - 1);
  assign cond.c_more   = (c_r != last_r);
  assign cond.out_busy = out_busy;

  // active count clipped to 1..NUM_CENTERS
  assign act_ext = EW'(act_r);
  assign cnt = (act_ext == '0) ? EW'(1) :
               ((act_ext > EW'(NUM_CENTERS)) ? EW'(NUM_CENTERS) : act_ext);

  always_ff @(posedge clk) begin
    if (load_we) begin
      center_mem[wr_addr] <= in_center_value;
    end
  end

  always_ff @(posedge clk) begin
    if (query_we) begin
      qbuf_mem[DIDX_W'(in_component_index)] <= in_descriptor_value;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.issue) begin
      cv_r <= center_mem[addr_r];
      qv_r <= qbuf_mem[d_r];
    end
  end

  // q*256 - c always fits 17 signed bits
  always_comb begin
    diff  = $signed({1'b0, qv_r, 8'h00}) - $signed({1'b0, cv_r});
    mag   = diff[CVAL_W] ? CVAL_W'(-diff) : diff[CVAL_W-1:0];
    mag_w = {{(SQ_W-CVAL_W){1'b0}}, mag};
  end

  always_ff @(posedge clk) begin
    if (v1_r) begin
      sq_r <= mag_w * mag_w;
    end
  end

  always_comb begin
    c_nxt    = c_r;
    d_nxt    = d_r;
    addr_nxt = addr_r;
    if (ctrl.init) begin
      c_nxt    = '0;
      d_nxt    = '0;
      addr_nxt = '0;
    end else if (ctrl.issue) begin
      d_nxt    = DIDX_W'(d_r + 1'b1);
      addr_nxt = MEM_AW'(addr_r + 1'b1);
    end else if (ctrl.cmp) begin
      d_nxt = '0;
      c_nxt = CIDX_W'(c_r + 1'b1);
    end
  end

  assign take_best = (c_r == '0) || (acc_r < best_d_r);

  always_ff @(posedge clk) begin
    c_r    <= c_nxt;
    d_r    <= d_nxt;
    addr_r <= addr_nxt;
    if (ctrl.init) begin
      last_r <= CIDX_W'(cnt - 1'b1);
    end
    if (ctrl.init || ctrl.cmp) begin
      acc_r <= '0;
    end else if (v2_r) begin
      acc_r <= acc_r + ACC_W'(sq_r);
    end
    if (ctrl.cmp && take_best) begin
      best_d_r <= acc_r;
      best_c_r <= c_r;
    end
  end

  assign best_ext = SUM_W'(best_d_r);

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_c_r <= BEST_W'(best_c_r);
      out_d_r <= (best_ext > SUM_W'({DIST_W{1'b1}})) ? {DIST_W{1'b1}} :
                 best_ext[DIST_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r       <= ACTIVE_RESET;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        act_r <= cfg_wr_data;
      end
      v1_r <= ctrl.issue;
      v2_r <= v1_r;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_best_center   = out_c_r;
  assign out_best_distance = out_d_r;

endmodule

/* rtl/nca_checker.sv */
// Port-level checks for the nearest-centre assign unit, bound to the top level.
module nca_checker #(
  parameter int DIMENSIONS = nca_pkg::DIMENSIONS_DEF
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic [nca_pkg::MODE_W-1:0]    in_mode,
  input logic [nca_pkg::COMP_W-1:0]    in_component_index,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [nca_pkg::BEST_W-1:0]    out_best_center,
  input logic [nca_pkg::DIST_W-1:0]    out_best_distance
);
  import nca_pkg::*;

  logic acc_in;
  assign acc_in = in_valid && !in_stall;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_best_center) &&
    $stable(out_best_distance))
    else $error("stalled result changed");

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_load_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    acc_in && (in_mode == MODE_LOAD) |=> !in_stall)
    else $error("load request caused a stall");

  a_last_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    acc_in && (in_mode == MODE_QUERY) &&
    (32'(in_component_index) == DIMENSIONS - 1) |=> in_stall)
    else $error("final query component did not start a scan");

  a_result_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared while requests were open");

endmodule

bind nearest_centroid_assign_unit nca_checker #(.DIMENSIONS(DIMENSIONS)) u_nca_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .in_mode           (in_mode),
  .in_component_index(in_component_index),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_best_center   (out_best_center),
  .out_best_distance (out_best_distance)
);

/* sim/nearest_centroid_assign_unit_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the nearest-centre assign unit: loads, queries and scan lengths.
module nearest_centroid_assign_unit_tb;
  import nca_pkg::*;

  localparam int NC = NUM_CENTERS_DEF;
  localparam int DIMS = DIMENSIONS_DEF;
  localparam int LAST_COMP = DIMS - 1;
  localparam int STORE_DEPTH = NC * DIMS;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_REQUESTS = 190;
  // only centres 0 and 1 are ever scanned, so a clean run ends before this limit
  localparam longint CYCLE_LIMIT = 400_000;
  localparam logic [63:0] DIST_MAX = (64'd1 << DIST_W) - 64'd1;

  typedef struct packed {
    logic [BEST_W-1:0] best_center;
    logic [DIST_W-1:0] best_distance;
  } assignment_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [ACT_W-1:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic [MODE_W-1:0] in_mode = MODE_LOAD;
  logic [IN_CIDX_W-1:0] in_center_index = '0;
  logic [COMP_W-1:0] in_component_index = '0;
  logic [CVAL_W-1:0] in_center_value = '0;
  logic [DVAL_W-1:0] in_descriptor_value = '0;
  logic out_stall = 1'b0;
  logic in_stall;
  logic out_valid;
  logic [BEST_W-1:0] out_best_center;
  logic [DIST_W-1:0] out_best_distance;

  logic [CVAL_W-1:0] centre_model [STORE_DEPTH];
  logic [DVAL_W-1:0] query_model [DIMS];
  logic [ACT_W-1:0] active_model = ACTIVE_RESET;
  assignment_t expected_assignments [$];
  assignment_t head;

  int unsigned requests_sent = 0;
  int unsigned loads_sent = 0;
  int unsigned query_parts = 0;
  int unsigned results_checked = 0;
  int unsigned settings_written = 0;
  int unsigned failures = 0;
  longint unsigned cycle_count = 0;
  int unsigned burst_left = 0;
  bit bursty = 1'b1;
  int unsigned stall_run = 0;
  logic [1:0] stall_mode = 2'd0;
  logic [7:0] stall_phase = '0;

  nearest_centroid_assign_unit dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_mode             (in_mode),
    .in_center_index     (in_center_index),
    .in_component_index  (in_component_index),
    .in_center_value     (in_center_value),
    .in_descriptor_value (in_descriptor_value),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_best_center     (out_best_center),
    .out_best_distance   (out_best_distance)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic assignment_t nearest_centre();
    assignment_t r;
    int unsigned count;
    int unsigned c;
    int unsigned k;
    longint unsigned best_d;
    longint unsigned sum;
    longint diff;
    count = active_model;
    if (count == 0) count = 1;
    if (count > NC) count = NC;
    r = '0;
    best_d = 0;
    for (c = 0; c < count; c++) begin
      sum = 0;
      for (k = 0; k < DIMS; k++) begin
        diff = 256 * longint'(query_model[k]) - longint'(centre_model[c * DIMS + k]);
        if (diff < 0) diff = -diff;
        sum += longint'(diff * diff);
      end
      if (c == 0 || sum < best_d) begin
        best_d = sum;
        r.best_center = BEST_W'(c);
      end
    end
    if (best_d > DIST_MAX) best_d = DIST_MAX;
    r.best_distance = DIST_W'(best_d);
    return r;
  endfunction

  task automatic send_request(input logic [MODE_W-1:0] mode, input logic [IN_CIDX_W-1:0] cidx,
                              input logic [COMP_W-1:0] comp, input logic [CVAL_W-1:0] cval,
                              input logic [DVAL_W-1:0] dval);
    int unsigned gap;
    if (bursty && burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = $urandom_range(0, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    if (burst_left != 0) burst_left--;
    in_valid <= 1'b1;
    in_mode <= mode;
    in_center_index <= cidx;
    in_component_index <= comp;
    in_center_value <= cval;
    in_descriptor_value <= dval;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    requests_sent++;
    if (mode == MODE_LOAD) begin
      centre_model[int'(cidx) * DIMS + int'(comp)] = cval;
      loads_sent++;
    end else begin
      query_model[comp] = dval;
      query_parts++;
      if (comp == LAST_COMP) expected_assignments.push_back(nearest_centre());
    end
  endtask

  task automatic load_component(input int unsigned centre, input int unsigned comp,
                                input logic [CVAL_W-1:0] value);
    send_request(MODE_LOAD, IN_CIDX_W'(centre), COMP_W'(comp), value, DVAL_W'($urandom));
  endtask

  task automatic query_component(input int unsigned comp, input logic [DVAL_W-1:0] value);
    send_request(MODE_QUERY, IN_CIDX_W'($urandom), COMP_W'(comp), CVAL_W'($urandom), value);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_assignments.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_active_centres(input logic [ACT_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    active_model = value;
    settings_written++;
  endtask

  // result checker and receiver stall pattern
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (expected_assignments.size() == 0) begin
        $error("result with nothing expected: best_center %0d best_distance %0d",
               out_best_center, out_best_distance);
        failures++;
      end else begin
        head = expected_assignments.pop_front();
        results_checked++;
        if (out_best_center !== head.best_center) begin
          $error("best_center: expected %0d, got %0d", head.best_center, out_best_center);
          failures++;
        end
        if (out_best_distance !== head.best_distance) begin
          $error("best_distance: expected %0d, got %0d", head.best_distance, out_best_distance);
          failures++;
        end
      end
    end
    if (stall_run == 0) begin
      stall_mode = 2'($urandom_range(0, 3));
      stall_run = $urandom_range(8, 80);
    end
    stall_run--;
    stall_phase++;
    case (stall_mode)
      2'd0: out_stall <= 1'b0;
      2'd1: out_stall <= 1'($urandom_range(0, 1));
      2'd2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= stall_phase[1];
    endcase
  end

  // centre 0 filled back to back with zeros, then a query of all-0xFF components against it
  task automatic test_distance_extremes();
    int unsigned k;
    set_active_centres(ACT_W'(1));
    bursty = 1'b0;
    for (k = 0; k < DIMS; k++) load_component(0, k, 16'h0000);
    bursty = 1'b1;
    for (k = 0; k < DIMS; k++) query_component(k, 8'hFF);
    wait_drained();
  endtask

  // equal centres keep the lower index, a strictly closer one wins
  task automatic test_tie_first_index();
    int unsigned k;
    set_active_centres(ACT_W'(2));
    for (k = 0; k < DIMS; k++) load_component(1, k, 16'h0000);
    query_component(LAST_COMP, 8'hFF);
    load_component(1, 3, 16'hFF00);
    query_component(LAST_COMP, 8'hFF);
    load_component(0, 3, 16'hFF00);
    query_component(LAST_COMP, 8'hFF);
    wait_drained();
  endtask

  // zero count scans centre 0 alone; a load outside the scan changes nothing
  task automatic test_scan_counts();
    set_active_centres(ACT_W'(0));
    load_component(1, 7, 16'hFFFF);
    query_component(LAST_COMP, 8'hFF);
    wait_drained();
    set_active_centres(ACT_W'(2));
    load_component(NC - 1, 0, CVAL_W'($urandom));
    query_component(LAST_COMP, 8'hFF);
    wait_drained();
  endtask

  task automatic test_random_traffic();
    int unsigned base;
    int unsigned phase_end;
    int unsigned pick;
    int unsigned n;
    int unsigned i;
    base = requests_sent;
    while (requests_sent - base < RANDOM_REQUESTS) begin
      wait_drained();
      pick = $urandom_range(0, 9);
      set_active_centres(pick == 0 ? ACT_W'(0) : ACT_W'($urandom_range(1, 2)));
      phase_end = requests_sent + $urandom_range(30, 70);
      while (requests_sent < phase_end) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          n = $urandom_range(0, 6);
          for (i = 0; i < n; i++) query_component($urandom_range(0, LAST_COMP - 1), DVAL_W'($urandom));
          query_component(LAST_COMP, DVAL_W'($urandom));
        end else if (pick < 75) begin
          // pull a scanned centre towards the current descriptor
          i = $urandom_range(0, LAST_COMP);
          load_component($urandom_range(0, 1), i, {query_model[i], 8'($urandom)});
        end else if (pick < 85) begin
          load_component($urandom_range(0, NC - 1), $urandom_range(0, LAST_COMP), CVAL_W'($urandom));
        end else if (pick < 97) begin
          query_component($urandom_range(0, LAST_COMP), DVAL_W'($urandom));
        end else begin
          wait_drained();
        end
      end
    end
    wait_drained();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_distance_extremes();
    test_tie_first_index();
    test_scan_counts();
    test_random_traffic();
    wait_drained();
    $display("Checked %0d assignments from %0d requests (%0d centre loads, %0d query components).",
             results_checked, requests_sent, loads_sent, query_parts);
    $display("Scans of one or two centres, zero count and ties, %0d count settings, %0d failures.",
             settings_written, failures);
    if (failures == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
